>>> hdl/phc_pkg.sv
// Shared types and constants for the pH calibration core.
`default_nettype none
package phc_pkg;

  localparam int WINDOW_SIZE = 3;

  localparam int SAMPLE_W = 16;
  localparam int VOLT_W   = 23;
  localparam int FS_W     = 16;
  localparam int PH_W     = 16;
  localparam int CFG_IW   = 3;

  localparam int MUL_AW   = 23;
  localparam int MUL_BW   = 15;
  localparam int PROD_W   = MUL_AW + MUL_BW;
  localparam int DIV_NW   = PROD_W;
  localparam int DIV_DW   = 24;
  localparam int TOT_W    = 40;

  typedef logic [CFG_IW-1:0] cfg_index_t;

  localparam cfg_index_t REG_VREF    = 3'd0;
  localparam cfg_index_t REG_FS      = 3'd1;
  localparam cfg_index_t REG_CAL4    = 3'd2;
  localparam cfg_index_t REG_CAL686  = 3'd3;
  localparam cfg_index_t REG_CAL9    = 3'd4;

  localparam logic [VOLT_W-1:0] VREF_RESET = 23'd3300000;
  localparam logic [FS_W-1:0]   FS_RESET   = 16'd32767;
  localparam logic [VOLT_W-1:0] VOLT_MAX   = 23'd5000000;

  localparam logic [MUL_BW-1:0] SPAN_LOW  = 15'd2860;
  localparam logic [MUL_BW-1:0] SPAN_HIGH = 15'd2140;
  localparam logic signed [PH_W-1:0] BASE_LOW  = 16'sd4000;
  localparam logic signed [PH_W-1:0] BASE_HIGH = 16'sd6860;
  localparam logic signed [PH_W-1:0] PH_MAX    = 16'sd32767;
  localparam logic signed [PH_W-1:0] PH_MIN    = -16'sd32768;
  localparam logic signed [TOT_W-1:0] TOT_MAX  = 40'sd32767;
  localparam logic signed [TOT_W-1:0] TOT_MIN  = -40'sd32768;

endpackage
`default_nettype wire

>>> hdl/ph_median_piecewise_calibration_core.sv
// Top level of the median-of-three, two-segment pH calibration core.
// The first two samples of each triple are taken in one cycle each, even while the previous
// triple is still being worked on. The third sample starts the arithmetic and the next third
// sample waits until that result has been handed to the output register. When the block is
// calibrated and the full scale is nonzero, the result is computed by one shared bit-serial
// multiplier and one shared restoring divider, each used twice: once for the microvolt
// scaling and once for the segment interpolation; otherwise a divide or the interpolation is
// skipped and the word appears sooner. A finished word waits in the output register while
// new samples are taken. Configuration writes are accepted in every cycle.
`default_nettype none
module ph_median_piecewise_calibration_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [phc_pkg::CFG_IW-1:0]          cfg_index,
  input  wire logic [phc_pkg::VOLT_W-1:0]          cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [phc_pkg::SAMPLE_W-1:0] sample,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [phc_pkg::PH_W-1:0]          ph_milli,
  output logic [phc_pkg::VOLT_W-1:0]               voltage_uv,
  output logic                                     calibrated,
  output logic                                     saturated
);

  localparam int WINDOW_SIZE = phc_pkg::WINDOW_SIZE;
  localparam int FW = $clog2(WINDOW_SIZE);
  localparam int IW = $clog2(WINDOW_SIZE - 1);
  localparam int VW = phc_pkg::VOLT_W;
  localparam int BW = phc_pkg::MUL_BW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_DIV1, ST_SEG, ST_MUL2, ST_DIV2, ST_FIN
  } state_t;

  state_t state;

  logic [VW-1:0]                vref_uv;
  logic [phc_pkg::FS_W-1:0]     adc_full_scale;
  logic [VW-1:0]                cal_ph4_uv;
  logic [VW-1:0]                cal_ph686_uv;
  logic [VW-1:0]                cal_ph9_uv;

  logic signed [phc_pkg::SAMPLE_W-1:0] window [WINDOW_SIZE-1];
  logic [FW-1:0]                fill;
  logic                         in_acc;
  logic                         accept3;

  logic signed [phc_pkg::SAMPLE_W-1:0] mn, mx, mn2, md;
  logic [BW-1:0]                med15;
  logic [BW-1:0]                med_r;
  logic [VW-1:0]                volt_r;

  logic                         mul_start, mul_done;
  logic [phc_pkg::MUL_AW-1:0]   mul_a;
  logic [BW-1:0]                mul_b;
  logic [phc_pkg::PROD_W-1:0]   prod;
  logic                         div_start, div_done;
  logic [phc_pkg::DIV_NW-1:0]   div_n;
  logic [phc_pkg::DIV_DW-1:0]   div_d;
  logic [phc_pkg::DIV_NW-1:0]   quo;

  logic                         cal;
  logic                         seg_low;
  logic [VW-1:0]                lo, hi;
  logic [VW:0]                  diff, den, ndiff, nden;
  logic [VW-1:0]                absdiff, absden;
  logic                         den_zero;
  logic                         neg;
  logic [BW-1:0]                span;
  logic signed [phc_pkg::PH_W-1:0] base;
  logic signed [phc_pkg::PH_W-1:0] ph_special;

  logic                         seg_neg;
  logic [VW-1:0]                seg_ad;
  logic signed [phc_pkg::PH_W-1:0] seg_base;
  logic                         cal_r;
  logic signed [phc_pkg::PH_W-1:0] ph_r;
  logic                         sat_r;

  logic [phc_pkg::TOT_W-1:0]    q_ext;
  logic signed [phc_pkg::TOT_W-1:0] total;

  assign cfg_ready = 1'b1;
  assign in_ready  = (fill != FW'(WINDOW_SIZE - 1)) || (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign accept3   = in_acc && (fill == FW'(WINDOW_SIZE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      vref_uv        <= phc_pkg::VREF_RESET;
      adc_full_scale <= phc_pkg::FS_RESET;
      cal_ph4_uv     <= '0;
      cal_ph686_uv   <= '0;
      cal_ph9_uv     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        phc_pkg::REG_VREF:   vref_uv        <= cfg_data;
        phc_pkg::REG_FS:     adc_full_scale <= cfg_data[phc_pkg::FS_W-1:0];
        phc_pkg::REG_CAL4:   cal_ph4_uv     <= cfg_data;
        phc_pkg::REG_CAL686: cal_ph686_uv   <= cfg_data;
        phc_pkg::REG_CAL9:   cal_ph9_uv     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
        window[i] <= '0;
      end
    end else if (in_acc) begin
      if (fill == FW'(WINDOW_SIZE - 1)) begin
        fill <= '0;
      end else begin
        window[fill[IW-1:0]] <= sample;
        fill <= fill + FW'(1);
      end
    end
  end

  always_comb begin
    mn    = (window[0] < window[1]) ? window[0] : window[1];
    mx    = (window[0] < window[1]) ? window[1] : window[0];
    mn2   = (mx < sample) ? mx : sample;
    md    = (mn > mn2) ? mn : mn2;
    med15 = md[phc_pkg::SAMPLE_W-1] ? '0 : md[BW-1:0];
  end

  always_comb begin
    cal      = (cal_ph4_uv != '0) && (cal_ph686_uv != '0) && (cal_ph9_uv != '0);
    seg_low  = volt_r < cal_ph686_uv;
    lo       = seg_low ? cal_ph4_uv : cal_ph686_uv;
    hi       = seg_low ? cal_ph686_uv : cal_ph9_uv;
    span     = seg_low ? phc_pkg::SPAN_LOW : phc_pkg::SPAN_HIGH;
    base     = seg_low ? phc_pkg::BASE_LOW : phc_pkg::BASE_HIGH;
    diff     = {1'b0, volt_r} - {1'b0, lo};
    den      = {1'b0, hi} - {1'b0, lo};
    ndiff    = ~diff + {{VW{1'b0}}, 1'b1};
    nden     = ~den + {{VW{1'b0}}, 1'b1};
    absdiff  = diff[VW] ? ndiff[VW-1:0] : diff[VW-1:0];
    absden   = den[VW] ? nden[VW-1:0] : den[VW-1:0];
    den_zero = (den == '0);
    neg      = diff[VW] ^ den[VW];
    if (diff[VW]) begin
      ph_special = phc_pkg::PH_MIN;
    end else if (diff != '0) begin
      ph_special = phc_pkg::PH_MAX;
    end else begin
      ph_special = base;
    end
  end

  assign mul_start = accept3 || ((state == ST_SEG) && cal && !den_zero);
  assign mul_a     = (state == ST_IDLE) ? vref_uv : absdiff;
  assign mul_b     = (state == ST_IDLE) ? med15 : span;

  assign div_start = mul_done && (((state == ST_MUL1) && (adc_full_scale != '0))
                                  || (state == ST_MUL2));
  assign div_n     = (state == ST_MUL1) ? prod
                   : ({prod[phc_pkg::PROD_W-2:0], 1'b0}
                      + {{(phc_pkg::DIV_NW - VW){1'b0}}, seg_ad});
  assign div_d     = (state == ST_MUL1)
                   ? {{(phc_pkg::DIV_DW - phc_pkg::FS_W){1'b0}}, adc_full_scale}
                   : {seg_ad, 1'b0};

  assign q_ext = {{(phc_pkg::TOT_W - phc_pkg::DIV_NW){1'b0}}, quo};
  assign total = {{(phc_pkg::TOT_W - phc_pkg::PH_W){seg_base[phc_pkg::PH_W-1]}}, seg_base}
               + (seg_neg ? (~q_ext + {{(phc_pkg::TOT_W-1){1'b0}}, 1'b1}) : q_ext);

  phc_serial_mul #(
    .AW(phc_pkg::MUL_AW),
    .BW(phc_pkg::MUL_BW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  phc_serial_div #(
    .NW(phc_pkg::DIV_NW),
    .DW(phc_pkg::DIV_DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept3) begin
            med_r <= med15;
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          if (mul_done) begin
            if (adc_full_scale == '0) begin
              volt_r <= (med_r == '0) ? '0 : phc_pkg::VOLT_MAX;
              state  <= ST_SEG;
            end else begin
              state <= ST_DIV1;
            end
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            volt_r <= (quo > {{(phc_pkg::DIV_NW - VW){1'b0}}, phc_pkg::VOLT_MAX})
                    ? phc_pkg::VOLT_MAX : quo[VW-1:0];
            state  <= ST_SEG;
          end
        end
        ST_SEG: begin
          cal_r <= cal;
          if (!cal) begin
            ph_r  <= '0;
            sat_r <= 1'b0;
            state <= ST_FIN;
          end else if (den_zero) begin
            ph_r  <= ph_special;
            sat_r <= 1'b1;
            state <= ST_FIN;
          end else begin
            seg_neg  <= neg;
            seg_ad   <= absden;
            seg_base <= base;
            state    <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          if (mul_done) begin
            state <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            if (total > phc_pkg::TOT_MAX) begin
              ph_r  <= phc_pkg::PH_MAX;
              sat_r <= 1'b1;
            end else if (total < phc_pkg::TOT_MIN) begin
              ph_r  <= phc_pkg::PH_MIN;
              sat_r <= 1'b1;
            end else begin
              ph_r  <= total[phc_pkg::PH_W-1:0];
              sat_r <= 1'b0;
            end
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            ph_milli   <= ph_r;
            voltage_uv <= volt_r;
            calibrated <= cal_r;
            saturated  <= sat_r;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_mul_done_phase: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_MUL1 || state == ST_MUL2))
    else $error("Multiplier finished outside a multiply phase.");

  a_div_done_phase: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV1 || state == ST_DIV2))
    else $error("Divider finished outside a divide phase.");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(WINDOW_SIZE - 1))
    else $error("Window fill count out of range.");

  a_volt_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (voltage_uv <= phc_pkg::VOLT_MAX))
    else $error("Output voltage word above the saturation limit.");

  a_uncal_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !calibrated) |-> (ph_milli == '0 && !saturated))
    else $error("Uncalibrated word carries a pH value or saturation flag.");

endmodule
`default_nettype wire

>>> hdl/phc_serial_mul.sv
// Shift-and-add multiplier that retires one multiplier bit per cycle.
`default_nettype none
module phc_serial_mul #(
  parameter int AW = 23,
  parameter int BW = 15
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [AW-1:0] a,
  input  wire logic [BW-1:0] b,
  output logic               done,
  output logic [AW+BW-1:0]   prod
);

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [PW-1:0] p;
  logic [AW-1:0] a_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [AW:0]   sum;

  assign sum  = {1'b0, p[PW-1:BW]} + {1'b0, (p[0] ? a_r : {AW{1'b0}})};
  assign prod = p;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(BW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p   <= {{AW{1'b0}}, b};
      a_r <= a;
    end else if (busy) begin
      p <= {sum, p[BW-1:1]};
    end
  end

endmodule
`default_nettype wire

>>> hdl/phc_serial_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module phc_serial_div #(
  parameter int NW = 38,
  parameter int DW = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [NW-1:0] quo;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial    = {rem, quo[NW-1]};
  assign diff     = trial - {1'b0, d_r};
  assign ge       = ~diff[DW];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      d_r <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule
`default_nettype wire
